>>> design/plcpp_pkg.sv
// Package for the preamble/length/checksum packet parser.
// Holds the shared result type, mode and kind codes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package plcpp_pkg;

  // Number of preamble bytes matched before the length byte.
  localparam int PreambleLen = 3;

  // Configuration register indexes.
  localparam logic CfgPreamble = 1'b0;
  localparam logic CfgMinLen   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [23:0] PreambleReset = 24'h03AFEF;
  localparam logic [7:0]  MinLenReset   = 8'd4;

  // Error codes beyond the preamble byte indexes.
  localparam logic [2:0] CodeShort = 3'd3;
  localparam logic [2:0] CodeCheck = 3'd4;

  typedef enum logic [3:0] {
    ModePre = 4'b0001,
    ModeLen = 4'b0010,
    ModePay = 4'b0100,
    ModeErr = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    KindHdr  = 2'd0,
    KindData = 2'd1,
    KindOk   = 2'd2,
    KindErr  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [2:0] error_code;
  } result_t;

endpackage

>>> design/plcpp_core.sv
// Parser core: configuration registers, parse state and the per-byte decision.
// Depends on plcpp_pkg.
`timescale 1ns / 1ps

module plcpp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  input  logic              byte_fire_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  output plcpp_pkg::result_t res_o
);
  import plcpp_pkg::*;

  logic [23:0] pattern_q;
  logic [7:0]  min_len_q;
  mode_e       mode_q, mode_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  idx_q, idx_d;

  logic [1:0]  idx_sel;
  logic [1:0]  idx_inc;
  logic [7:0]  expected;
  logic [7:0]  chk_x;
  logic        hit;

  // An index at or past the preamble length is treated as the first byte.
  assign idx_sel = (idx_q >= 2'(PreambleLen)) ? 2'd0 : idx_q;
  assign idx_inc = idx_sel + 2'd1;
  assign chk_x   = chk_q ^ rx_byte_i;
  assign hit     = (rx_byte_i == expected);

  always_comb begin
    unique case (idx_sel)
      2'd1:    expected = pattern_q[15:8];
      2'd2:    expected = pattern_q[7:0];
      default: expected = pattern_q[23:16];
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    chk_d       = chk_x;
    left_d      = left_q;
    idx_d       = idx_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindErr, value: 8'd0, error_code: 3'd0};

    unique case (mode_q)
      ModePre: begin
        if (!hit) begin
          res_valid_o = 1'b1;
          res_o.error_code = {1'b0, idx_sel};
          chk_d  = 8'd0;
          idx_d  = 2'd0;
          mode_d = ModeErr;
        end else if (idx_inc >= 2'(PreambleLen)) begin
          idx_d  = 2'd0;
          mode_d = ModeLen;
        end else begin
          idx_d = idx_inc;
        end
      end
      ModeLen: begin
        res_valid_o = 1'b1;
        if (rx_byte_i < min_len_q) begin
          res_o.error_code = CodeShort;
          chk_d  = 8'd0;
          mode_d = ModeErr;
        end else begin
          left_d = rx_byte_i - 8'(PreambleLen + 1);
          res_o  = '{kind: KindHdr, value: left_d, error_code: 3'd0};
          mode_d = ModePay;
        end
      end
      ModePay: begin
        res_valid_o = 1'b1;
        if (left_q > 8'd1) begin
          left_d = left_q - 8'd1;
          res_o  = '{kind: KindData, value: rx_byte_i, error_code: 3'd0};
        end else begin
          left_d = 8'd0;
          if (chk_x != 8'd0) begin
            res_o.error_code = CodeCheck;
            chk_d  = 8'd0;
            mode_d = ModeErr;
          end else begin
            res_o  = '{kind: KindOk, value: 8'd0, error_code: 3'd0};
            mode_d = ModePre;
          end
        end
      end
      default: begin
        // Silent search for a full preamble after an error.
        if (!hit) begin
          idx_d = 2'd0;
          chk_d = 8'd0;
        end else if (idx_inc >= 2'(PreambleLen)) begin
          idx_d  = 2'd0;
          mode_d = ModeLen;
        end else begin
          idx_d = idx_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PreambleReset;
      min_len_q <= MinLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPreamble: pattern_q <= cfg_data_i;
        default:     min_len_q <= cfg_data_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePre;
      chk_q  <= 8'd0;
      left_q <= 8'd0;
      idx_q  <= 2'd0;
    end else if (byte_fire_i) begin
      mode_q <= mode_d;
      chk_q  <= chk_d;
      left_q <= left_d;
      idx_q  <= idx_d;
    end
  end

endmodule

>>> design/plcpp_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Depends on plcpp_pkg.
`timescale 1ns / 1ps

module plcpp_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  plcpp_pkg::result_t push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output plcpp_pkg::result_t out_data_o
);
  import plcpp_pkg::*;

  logic    main_vld_q, main_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    main_free;

  // The skid entry is only ever occupied while the main entry is.
  assign space_o     = !skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;
  assign main_free   = !main_vld_q || out_ready_i;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (main_free) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_vld_d = 1'b0;
      end else if (push_i) begin
        main_d     = push_data_i;
        main_vld_d = 1'b1;
      end else begin
        main_vld_d = 1'b0;
      end
    end else if (push_i) begin
      skid_d     = push_data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

>>> design/preamble_length_checksum_packet_parser_top.sv
// Top level of the preamble/length/checksum packet parser.
// Depends on plcpp_pkg, plcpp_core and plcpp_out_buf.
`timescale 1ns / 1ps

// The parser takes one received byte per input transaction and produces at
// most one result transaction for it: a length header, a payload byte, a
// packet-accepted marker or an error. Every byte is decided in the cycle it
// is accepted by the parse state registers in the core, and its result is
// registered in a two-entry buffer (output register plus skid register),
// so the block sustains one byte per clock cycle while a buffer entry is
// free; in_ready_o drops only when both entries hold results that the
// downstream side has not taken, so one stalled result never blocks the
// next byte. Configuration writes land at the clock edge where cfg_we_i is
// high and should be issued only while no result is pending.

module preamble_length_checksum_packet_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port: index 0 preamble pattern, index 1 min length.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // Input byte channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  value_o,
  output logic [2:0]  error_code_o
);
  import plcpp_pkg::*;

  logic    byte_fire;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    space;

  // A byte is accepted whenever the result buffer still has a free entry.
  assign in_ready_o = space;
  assign byte_fire  = in_valid_i && space;

  plcpp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .byte_fire_i (byte_fire),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Only bytes that actually produce a result are pushed into the buffer.
  plcpp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (byte_fire && res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o       = out_data.kind;
  assign value_o      = out_data.value;
  assign error_code_o = out_data.error_code;

endmodule

>>> test/plcpp_frame_checker.sv
// Checker for the preamble/length/checksum packet parser.
// Watches the config port and both channels, predicts results, compares them.
// Depends on plcpp_pkg.
`timescale 1ns / 1ps

module plcpp_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  value_i,
  input  logic [2:0]  error_code_i,
  output int          fail_count_o,
  output int          pending_o
);
  import plcpp_pkg::*;

  logic [23:0] pattern   = PreambleReset;
  logic [7:0]  min_len   = MinLenReset;
  mode_e       mode      = ModePre;
  logic [7:0]  check_acc = '0;
  logic [7:0]  left      = '0;
  logic [1:0]  pre_idx   = '0;

  result_t parsed_q[$];
  int      fails = 0;

  function automatic logic [7:0] pattern_byte(input logic [1:0] idx);
    case (idx)
      2'd1:    return pattern[15:8];
      2'd2:    return pattern[7:0];
      default: return pattern[23:16];
    endcase
  endfunction

  function automatic result_t flag_error(input logic [2:0] code);
    check_acc = '0;
    mode      = ModeErr;
    return '{kind: KindErr, value: 8'h00, error_code: code};
  endfunction

  // Advances the parse state by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] c, output result_t r);
    logic [1:0] idx;
    bit         got;
    idx = (pre_idx >= PreambleLen) ? 2'd0 : pre_idx;
    check_acc ^= c;
    r   = '{kind: KindHdr, value: 8'h00, error_code: 3'd0};
    got = 1'b0;
    case (mode)
      ModePre: begin
        if (c != pattern_byte(idx)) begin
          pre_idx = '0;
          r       = flag_error({1'b0, idx});
          got     = 1'b1;
        end else begin
          idx++;
          if (idx >= PreambleLen) begin
            idx  = '0;
            mode = ModeLen;
          end
          pre_idx = idx;
        end
      end
      ModeLen: begin
        if (c < min_len) begin
          r = flag_error(CodeShort);
        end else begin
          // Header wraps modulo 256 when the length byte is below four.
          left    = c - 8'(PreambleLen + 1);
          mode    = ModePay;
          r.kind  = KindHdr;
          r.value = left;
        end
        got = 1'b1;
      end
      ModePay: begin
        if (left > 8'd1) begin
          left--;
          r.kind  = KindData;
          r.value = c;
        end else begin
          left = '0;
          if (check_acc != 8'h00) begin
            r = flag_error(CodeCheck);
          end else begin
            mode   = ModePre;
            r.kind = KindOk;
          end
        end
        got = 1'b1;
      end
      default: begin
        // Silent search: a failed byte is not retried as a first byte.
        if (c == pattern_byte(idx)) begin
          idx++;
        end else begin
          idx       = '0;
          check_acc = '0;
        end
        if (idx >= PreambleLen) begin
          idx  = '0;
          mode = ModeLen;
        end
        pre_idx = idx;
      end
    endcase
    return got;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t r;
    result_t want;
    if (!rst_ni) begin
      pattern   = PreambleReset;
      min_len   = MinLenReset;
      mode      = ModePre;
      check_acc = '0;
      left      = '0;
      pre_idx   = '0;
      parsed_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPreamble) pattern = cfg_data_i;
        else min_len = cfg_data_i[7:0];
      end
      if (in_valid_i && in_ready_i) begin
        if (deframe_byte(rx_byte_i, r)) parsed_q.push_back(r);
      end
      if (out_valid_i && out_ready_i) begin
        if (parsed_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with none due: kind %0d value %02h code %0d",
                     $realtime, kind_i, value_i, error_code_i);
        end else begin
          want = parsed_q.pop_front();
          if (kind_i !== want.kind || value_i !== want.value ||
              error_code_i !== want.error_code) begin
            fails++;
            if (fails <= 10)
              $display("%0t: exp kind %0d val %02h code %0d, got kind %0d val %02h code %0d",
                       $realtime, want.kind, want.value, want.error_code,
                       kind_i, value_i, error_code_i);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= parsed_q.size();
  end

endmodule

>>> test/tb.sv
// Top of the packet parser testbench: clock, reset, stimulus and verdict.
// Depends on plcpp_pkg, plcpp_frame_checker and the parser top level.
`timescale 1ns / 1ps

module tb;
  import plcpp_pkg::*;

  // Long receiver hold-off, and the quiet time allowed after the last result
  // before a configuration write or the verdict (the block registers each
  // result at the edge where it accepts the byte).
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = CfgPreamble;
  logic [23:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  value_o;
  logic [2:0]  error_code_o;

  int fail_count;
  int pending;

  // Shared between the stimulus and the result sink: idle_on switches the
  // random gaps on both sides, hold_req asks the sink for one long hold-off.
  bit          idle_on     = 1'b1;
  int          hold_req    = 0;
  int          hold_done   = 0;
  int          bytes_sent  = 0;
  logic [23:0] cur_pattern = PreambleReset;
  logic [7:0]  cur_min     = MinLenReset;

  always #4 clk_i = ~clk_i;

  preamble_length_checksum_packet_parser_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .error_code_o (error_code_o)
  );

  plcpp_frame_checker frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_i       (kind_o),
    .value_i      (value_o),
    .error_code_i (error_code_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Preamble byte j of the pattern currently programmed into the block.
  function automatic logic [7:0] pre_byte(input int j);
    return cur_pattern[23 - 8 * j -: 8];
  endfunction

  // Offers one byte after a random gap and returns at the edge where the
  // input transaction completes. Valid stays high into the next call when
  // that call draws no gap, so back-to-back bytes are never broken up.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    bytes_sent++;
  endtask

  // The sender stops and waits until every predicted result has been taken,
  // then lets the block settle. The first edge is spent so that the pending
  // count already covers a byte accepted at the edge of the call.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive edges with the enable held high.
  task automatic set_config(input logic [23:0] pattern, input logic [7:0] min_len);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgPreamble;
    cfg_data_i  <= pattern;
    @(posedge clk_i);
    cfg_index_i <= CfgMinLen;
    cfg_data_i  <= {16'h0000, min_len};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_pattern = pattern;
    cur_min     = min_len;
  endtask

  // A whole frame: preamble, length byte, payload and a final byte that
  // brings the XOR to zero, or to a nonzero value when corrupt is set.
  task automatic send_frame(input logic [7:0] len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] left;
    int         n;
    sum = len;
    for (int j = 0; j < PreambleLen; j++) begin
      b = pre_byte(j);
      sum ^= b;
      push_byte(b);
    end
    push_byte(len);
    left = len - 8'(PreambleLen + 1);
    // A count of zero or one means the next byte is already the final one.
    n = (left > 8'd1) ? int'(left) : 1;
    repeat (n - 1) begin
      b = 8'($urandom_range(0, 255));
      sum ^= b;
      push_byte(b);
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    push_byte(sum);
  endtask

  // Random traffic: mostly well-formed frames with random content and short
  // lengths, the rest broken preambles, short length bytes and loose noise.
  task automatic run_traffic(input int count);
    int         stop;
    int         pick;
    int         k;
    logic [7:0] len;
    logic [7:0] lo;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      lo   = (cur_min > 8'd4) ? cur_min : 8'd4;
      if (pick < 65) begin
        k = $urandom_range(0, 99);
        // Lengths below four wrap the count and make very long frames, so
        // they are rare, as are large lengths in general.
        if (k < 2 && cur_min < 8'd4) len = 8'($urandom_range(cur_min, 3));
        else if (k < 3) len = 8'($urandom_range(lo, 255));
        else len = (lo > 8'd241) ? 8'd255 : lo + 8'($urandom_range(0, 14));
        send_frame(len, $urandom_range(0, 6) == 0);
      end else if (pick < 77) begin
        k = $urandom_range(0, PreambleLen - 1);
        for (int j = 0; j < k; j++) push_byte(pre_byte(j));
        push_byte(pre_byte(k) ^ 8'($urandom_range(1, 255)));
      end else if (pick < 85 && cur_min > 8'd0) begin
        for (int j = 0; j < PreambleLen; j++) push_byte(pre_byte(j));
        push_byte(8'($urandom_range(0, cur_min - 1)));
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result sink: a random gap before each result transaction, and a long
  // hold-off whenever the stimulus asks for one. During the hold-off the
  // sender keeps offering bytes, so the output buffer fills and the block
  // has to drop in_ready_o.
  initial begin : result_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_done != hold_req) begin
        hold_done++;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // The limit lies well above the slowest correct run; past it the run is
  // declared hung.
  initial begin : watchdog
    #4_000_000;
    $display("preamble_length_checksum_packet_parser_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset settings. A good frame with a count of
    // one, then a mismatch on the third preamble byte while reporting.
    send_frame(8'd5, 1'b0);
    push_byte(pre_byte(0));
    push_byte(pre_byte(1));
    push_byte(8'hFF);
    // A silent mismatch during the search, a found preamble and a length
    // byte under the minimum.
    push_byte(8'h00);
    for (int j = 0; j < PreambleLen; j++) push_byte(pre_byte(j));
    push_byte(8'h02);
    // A count of zero with a bad checksum, then a clean frame that brings
    // the parser back to reporting, then a mismatch on the first byte.
    send_frame(8'd4, 1'b1);
    send_frame(8'd6, 1'b0);
    push_byte(8'h00);

    // Random traffic with the reset settings. Halfway through the sink
    // holds off for a long stretch; later the sender waits for all results.
    run_traffic(200);
    hold_req++;
    run_traffic(100);
    wait_drained();
    run_traffic(100);

    // Random pattern with no length minimum, so wrapping lengths can occur.
    set_config(24'($urandom_range(0, 24'hFFFFFF)), 8'd0);
    run_traffic(300);

    // Both registers at their top values: only a length of 255 passes.
    set_config(24'hFFFFFF, 8'd255);
    run_traffic(300);

    // An all-zero preamble, where the repeated bytes stress the search.
    set_config(24'h000000, 8'd4);
    run_traffic(250);

    set_config(24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(1, 12)));
    run_traffic(300);

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("preamble_length_checksum_packet_parser_top regression: pass");
    end else begin
      $display("preamble_length_checksum_packet_parser_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/plcpp_pkg.sv
design/plcpp_core.sv
design/plcpp_out_buf.sv
design/preamble_length_checksum_packet_parser_top.sv
test/plcpp_frame_checker.sv
test/tb.sv
